// ===== hdl/wavhp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package wavhp_pkg;

    localparam int HEADER_LEN = 44;
    localparam int NUM_FIELDS = 13;

    localparam logic [5:0] LAST_POS = 6'(HEADER_LEN - 1);

    // first byte of each header field
    localparam logic [5:0] FLD_START [NUM_FIELDS] = '{
        6'd0, 6'd4, 6'd8, 6'd12, 6'd16, 6'd20, 6'd22,
        6'd24, 6'd28, 6'd32, 6'd34, 6'd36, 6'd40
    };

    // offset of the final byte within each field
    localparam logic [1:0] FLD_LAST_K [NUM_FIELDS] = '{
        2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd1, 2'd1,
        2'd3, 2'd3, 2'd1, 2'd1, 2'd3, 2'd3
    };

    // bit 7: tag, low bits give the status code; otherwise the store slot
    localparam logic [7:0] FLD_KIND [NUM_FIELDS] = '{
        8'h81, 8'h00, 8'h82, 8'h83, 8'h01, 8'h02, 8'h03,
        8'h04, 8'h05, 8'h06, 8'h07, 8'h84, 8'h08
    };

    localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
    localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_BAD_RIFF = 3'd1,
        ST_BAD_WAVE = 3'd2,
        ST_BAD_FMT  = 3'd3,
        ST_BAD_DATA = 3'd4,
        ST_ZERO_DIV = 3'd5
    } t_status;

    typedef enum logic [3:0] {
        SLOT_RIFF_SIZE  = 4'd0,
        SLOT_FMT_SIZE   = 4'd1,
        SLOT_FORMAT_TAG = 4'd2,
        SLOT_CHANNELS   = 4'd3,
        SLOT_SAMPLE_RT  = 4'd4,
        SLOT_BYTE_RT    = 4'd5,
        SLOT_BLK_ALIGN  = 4'd6,
        SLOT_BITS       = 4'd7,
        SLOT_DATA_SIZE  = 4'd8
    } t_slot;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_DIV1,
        S_DIV2,
        S_OUT
    } t_state;

    typedef struct packed {
        t_status     err;
        logic [31:0] riff_size;
        logic [31:0] fmt_chunk_size;
        logic [15:0] format_tag;
        logic [15:0] channel_count;
        logic [31:0] frame_rate;
        logic [31:0] bytes_per_sec;
        logic [15:0] block_align;
        logic [15:0] bits_per_sample;
        logic [31:0] data_bytes;
    } t_hdr;

    typedef struct packed {
        t_status     status;
        logic [31:0] fmt_chunk_size;
        logic [15:0] format_tag;
        logic [15:0] channel_count;
        logic [31:0] frame_rate;
        logic [31:0] bytes_per_sec;
        logic [15:0] block_align;
        logic [15:0] bits_per_sample;
        logic [31:0] data_bytes;
        logic [31:0] file_size;
        logic [31:0] sample_count;
    } t_result;

    function automatic logic [3:0] field_index(input logic [5:0] pos);
        logic [3:0] f;
        f = 4'd0;
        for (int i = 0; i < NUM_FIELDS; i++) begin
            if (pos >= FLD_START[i]) begin
                f = 4'(i);
            end
        end
        return f;
    endfunction

    function automatic logic [31:0] tag_value(input t_status code);
        logic [31:0] v;
        unique case (code)
            ST_BAD_RIFF: v = TAG_RIFF;
            ST_BAD_WAVE: v = TAG_WAVE;
            ST_BAD_FMT:  v = TAG_FMT;
            ST_BAD_DATA: v = TAG_DATA;
            default:     v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/wavhp_ifs.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface wavhp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] header_byte;
    logic       start_req;

    modport source (output valid, header_byte, start_req, input ready);
    modport sink   (input valid, header_byte, start_req, output ready);
endinterface

interface wavhp_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [31:0] fmt_chunk_size;
    logic [15:0] format_tag;
    logic [15:0] channel_count;
    logic [31:0] frame_rate;
    logic [31:0] bytes_per_sec;
    logic [15:0] block_align;
    logic [15:0] bits_per_sample;
    logic [31:0] data_bytes;
    logic [31:0] file_size;
    logic [31:0] sample_count;

    modport source (
        output valid, status, fmt_chunk_size, format_tag, channel_count, frame_rate,
               bytes_per_sec, block_align, bits_per_sample, data_bytes, file_size,
               sample_count,
        input  ready
    );
    modport sink (
        input  valid, status, fmt_chunk_size, format_tag, channel_count, frame_rate,
               bytes_per_sec, block_align, bits_per_sample, data_bytes, file_size,
               sample_count,
        output ready
    );
endinterface

`default_nettype wire

// ===== hdl/wavhp_assembler.sv =====
`timescale 1ns / 1ps
`default_nettype none

module wavhp_assembler
    import wavhp_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_start,
    input  wire logic       i_big_endian,
    output logic            o_last,
    output t_hdr            o_hdr
);

    logic [5:0]  r_pos,    n_pos;
    logic        r_active, n_active;
    logic [31:0] r_word,   n_word;
    t_status     r_err,    n_err;
    t_hdr        r_hdr,    n_hdr;

    logic        act;
    logic [5:0]  pos;
    logic [31:0] word_base;
    t_status     err_base;
    logic [3:0]  fidx;
    logic [5:0]  k_full;
    logic [1:0]  k;
    logic [7:0]  kind;
    logic        field_end;
    t_status     code;

    always_comb begin
        act       = i_accept && (i_start || r_active);
        pos       = i_start ? 6'd0 : r_pos;
        word_base = i_start ? 32'd0 : r_word;
        err_base  = i_start ? ST_OK : r_err;
        fidx      = field_index(pos);
        k_full    = pos - FLD_START[fidx];
        k         = k_full[1:0];
        kind      = FLD_KIND[fidx];
        field_end = (k == FLD_LAST_K[fidx]);
        code      = t_status'(kind[2:0]);

        n_pos    = r_pos;
        n_active = r_active;
        n_word   = r_word;
        n_err    = r_err;
        n_hdr    = r_hdr;
        o_last   = 1'b0;

        if (act) begin
            n_word = (k == 2'd0) ? 32'd0 : word_base;
            // tags are always msb first
            if (kind[7] || i_big_endian) begin
                n_word = {n_word[23:0], i_byte};
            end else begin
                n_word = n_word | ({24'd0, i_byte} << {k, 3'b000});
            end

            n_err = err_base;
            if (field_end) begin
                if (kind[7]) begin
                    if (n_word != tag_value(code) && err_base == ST_OK) begin
                        n_err = code;
                    end
                end else begin
                    unique case (t_slot'(kind[3:0]))
                        SLOT_RIFF_SIZE:  n_hdr.riff_size       = n_word;
                        SLOT_FMT_SIZE:   n_hdr.fmt_chunk_size  = n_word;
                        SLOT_FORMAT_TAG: n_hdr.format_tag      = n_word[15:0];
                        SLOT_CHANNELS:   n_hdr.channel_count   = n_word[15:0];
                        SLOT_SAMPLE_RT:  n_hdr.frame_rate      = n_word;
                        SLOT_BYTE_RT:    n_hdr.bytes_per_sec   = n_word;
                        SLOT_BLK_ALIGN:  n_hdr.block_align     = n_word[15:0];
                        SLOT_BITS:       n_hdr.bits_per_sample = n_word[15:0];
                        SLOT_DATA_SIZE:  n_hdr.data_bytes      = n_word;
                        default: ;
                    endcase
                end
            end

            if (pos == LAST_POS) begin
                n_pos    = 6'd0;
                n_active = 1'b0;
                o_last   = 1'b1;
            end else begin
                n_pos    = pos + 6'd1;
                n_active = 1'b1;
            end
        end
        n_hdr.err = n_err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= 6'd0;
            r_active <= 1'b0;
            r_word   <= 32'd0;
            r_err    <= ST_OK;
            r_hdr    <= '0;
        end else begin
            r_pos    <= n_pos;
            r_active <= n_active;
            r_word   <= n_word;
            r_err    <= n_err;
            r_hdr    <= n_hdr;
        end
    end

    assign o_hdr = r_hdr;

endmodule

`default_nettype wire

// ===== hdl/wavhp_divider.sv =====
`timescale 1ns / 1ps
`default_nettype none

module wavhp_divider
    import wavhp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [31:0] i_dividend,
    input  wire logic [15:0] i_divisor,
    output logic             o_done,
    output logic [31:0]      o_quotient
);

    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [4:0]  r_cnt,  n_cnt;
    logic [15:0] r_rem,  n_rem;
    logic [31:0] r_quo,  n_quo;
    logic [15:0] r_div,  n_div;

    logic [16:0] rem_sh;
    logic [16:0] diff;
    logic        ge;

    // restoring division, one quotient bit per cycle
    always_comb begin
        rem_sh = {r_rem, r_quo[31]};
        diff   = rem_sh - {1'b0, r_div};
        ge     = (rem_sh >= {1'b0, r_div});

        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_div  = r_div;

        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = 5'd31;
            n_rem  = 16'd0;
            n_quo  = i_dividend;
            n_div  = i_divisor;
        end else if (r_busy) begin
            n_rem = ge ? diff[15:0] : rem_sh[15:0];
            n_quo = {r_quo[30:0], ge};
            n_cnt = r_cnt - 5'd1;
            if (r_cnt == 5'd0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 5'd0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_div <= n_div;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

// ===== hdl/wav_header_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Parses a canonical 44-byte RIFF/WAVE header that arrives one byte per request
// on i_in; a request with start_req set is byte 0 of a new header and drops any
// header in progress, and bytes outside a header are taken and ignored. The input
// stays ready for header bytes 0 to 42; after byte 43 it is held off while the
// result is built: S_EVAL settles the status, then, for a good header, S_DIV1 and
// S_DIV2 run two passes of the shared one-bit-per-cycle divider for data size /
// channels / (bits per sample / 8), then S_OUT loads the output register once
// o_out is free; an error status goes from S_EVAL straight to S_OUT.
// A result left waiting on o_out holds the input off only once the next header
// is complete. Tags are always compared msb first; numeric fields follow
// i_cfg_wr_data (1: msb first), which is to be written while the block is idle.
// On any error status every numeric field of the result is zero.
module wav_header_parser
    import wavhp_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_cfg_wr_en,
    input  wire logic  i_cfg_wr_data,
    wavhp_in_if.sink   i_in,
    wavhp_out_if.source o_out
);

    t_state      r_state, n_state;
    logic        r_big_endian;
    t_status     r_status, n_status;
    logic        r_out_valid, n_out_valid;
    t_result     r_out, n_out;

    logic        accept;
    logic        last;
    t_hdr        hdr;
    logic        div_start;
    logic [31:0] div_dividend;
    logic [15:0] div_divisor;
    logic        div_done;
    logic [31:0] div_quo;
    logic        load_out;
    logic        out_free;
    t_status     eval_status;

    assign accept   = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;

    wavhp_assembler u_asm (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_byte       (i_in.header_byte),
        .i_start      (i_in.start_req),
        .i_big_endian (r_big_endian),
        .o_last       (last),
        .o_hdr        (hdr)
    );

    wavhp_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    always_comb begin
        eval_status = hdr.err;
        if (hdr.err == ST_OK &&
            (hdr.channel_count == 16'd0 || hdr.bits_per_sample[15:3] == 13'd0)) begin
            eval_status = ST_ZERO_DIV;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (last) n_state = S_EVAL;
            S_EVAL: n_state = (eval_status == ST_OK) ? S_DIV1 : S_OUT;
            S_DIV1: if (div_done) n_state = S_DIV2;
            S_DIV2: if (div_done) n_state = S_OUT;
            S_OUT:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        i_in.ready   = 1'b0;
        div_start    = 1'b0;
        div_dividend = hdr.data_bytes;
        div_divisor  = hdr.channel_count;
        load_out     = 1'b0;
        n_status     = r_status;
        unique case (r_state)
            S_IDLE: i_in.ready = 1'b1;
            S_EVAL: begin
                n_status  = eval_status;
                div_start = (eval_status == ST_OK);
            end
            S_DIV1: begin
                // second pass divides the first quotient by whole bytes per sample
                div_start    = div_done;
                div_dividend = div_quo;
                div_divisor  = {3'd0, hdr.bits_per_sample[15:3]};
            end
            S_DIV2: ;
            S_OUT:  load_out = out_free;
            default: ;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end
        if (load_out) begin
            n_out_valid = 1'b1;
            n_out       = '0;
            n_out.status = r_status;
            if (r_status == ST_OK) begin
                n_out.fmt_chunk_size  = hdr.fmt_chunk_size;
                n_out.format_tag      = hdr.format_tag;
                n_out.channel_count   = hdr.channel_count;
                n_out.frame_rate      = hdr.frame_rate;
                n_out.bytes_per_sec   = hdr.bytes_per_sec;
                n_out.block_align     = hdr.block_align;
                n_out.bits_per_sample = hdr.bits_per_sample;
                n_out.data_bytes      = hdr.data_bytes;
                n_out.file_size       = hdr.riff_size + 32'd8;
                n_out.sample_count    = div_quo;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_big_endian <= 1'b0;
            r_status     <= ST_OK;
            r_out_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_status    <= n_status;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_big_endian <= i_cfg_wr_data;
            end
        end
        r_out <= n_out;
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.status          = r_out.status;
    assign o_out.fmt_chunk_size  = r_out.fmt_chunk_size;
    assign o_out.format_tag      = r_out.format_tag;
    assign o_out.channel_count   = r_out.channel_count;
    assign o_out.frame_rate      = r_out.frame_rate;
    assign o_out.bytes_per_sec   = r_out.bytes_per_sec;
    assign o_out.block_align     = r_out.block_align;
    assign o_out.bits_per_sample = r_out.bits_per_sample;
    assign o_out.data_bytes      = r_out.data_bytes;
    assign o_out.file_size       = r_out.file_size;
    assign o_out.sample_count    = r_out.sample_count;

endmodule

`default_nettype wire

// ===== hdl/wavhp_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module wavhp_checker
    import wavhp_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        i_ready,
    input wire logic [2:0]  i_status,
    input wire logic [31:0] i_fmt_chunk_size,
    input wire logic [15:0] i_format_tag,
    input wire logic [15:0] i_channel_count,
    input wire logic [31:0] i_frame_rate,
    input wire logic [31:0] i_bytes_per_sec,
    input wire logic [15:0] i_block_align,
    input wire logic [15:0] i_bits_per_sample,
    input wire logic [31:0] i_data_bytes,
    input wire logic [31:0] i_file_size,
    input wire logic [31:0] i_sample_count
);

    // an error result carries no numbers
    a_error_zeroes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_status != ST_OK) |->
            (i_fmt_chunk_size == 32'd0 && i_format_tag == 16'd0 &&
             i_channel_count == 16'd0 && i_frame_rate == 32'd0 &&
             i_bytes_per_sec == 32'd0 && i_block_align == 16'd0 &&
             i_bits_per_sample == 16'd0 && i_data_bytes == 32'd0 &&
             i_file_size == 32'd0 && i_sample_count == 32'd0))
        else $error("error result with nonzero fields");

    // a good result always had usable divisors
    a_ok_divisors: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_status == ST_OK) |->
            (i_channel_count != 16'd0 && i_bits_per_sample[15:3] != 13'd0))
        else $error("good result with zero divisor");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (i_status <= ST_ZERO_DIV))
        else $error("status code out of range");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_ready) |=> (i_valid && $stable(i_sample_count)))
        else $error("stalled result dropped or changed");

endmodule

bind wav_header_parser wavhp_checker u_chk (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_valid           (o_out.valid),
    .i_ready           (o_out.ready),
    .i_status          (o_out.status),
    .i_fmt_chunk_size  (o_out.fmt_chunk_size),
    .i_format_tag      (o_out.format_tag),
    .i_channel_count   (o_out.channel_count),
    .i_frame_rate      (o_out.frame_rate),
    .i_bytes_per_sec   (o_out.bytes_per_sec),
    .i_block_align     (o_out.block_align),
    .i_bits_per_sample (o_out.bits_per_sample),
    .i_data_bytes      (o_out.data_bytes),
    .i_file_size       (o_out.file_size),
    .i_sample_count    (o_out.sample_count)
);

`default_nettype wire

// ===== tb/wav_header_parser_tb.sv =====
`timescale 1ns / 1ps

module wav_header_parser_tb;
    import wavhp_pkg::*;

    localparam int HDR_BYTES = 44;
    localparam int SETTLE_CYCLES = 100;
    localparam int ITEM_TARGET = 1300;
    localparam int PRINT_LIMIT = 100;

    // field layout of the canonical header, in file order
    localparam int FIELD_AT [13] = '{0, 4, 8, 12, 16, 20, 22, 24, 28, 32, 34, 36, 40};
    localparam int FIELD_LEN [13] = '{4, 4, 4, 4, 4, 2, 2, 4, 4, 2, 2, 4, 4};
    // tag fields carry the status they raise, numeric fields carry ST_OK
    localparam t_status FIELD_TAG [13] = '{
        ST_BAD_RIFF, ST_OK, ST_BAD_WAVE, ST_BAD_FMT, ST_OK, ST_OK, ST_OK,
        ST_OK, ST_OK, ST_OK, ST_OK, ST_BAD_DATA, ST_OK
    };
    localparam t_slot FIELD_SLOT [13] = '{
        SLOT_RIFF_SIZE, SLOT_RIFF_SIZE, SLOT_RIFF_SIZE, SLOT_RIFF_SIZE, SLOT_FMT_SIZE,
        SLOT_FORMAT_TAG, SLOT_CHANNELS, SLOT_SAMPLE_RT, SLOT_BYTE_RT, SLOT_BLK_ALIGN,
        SLOT_BITS, SLOT_RIFF_SIZE, SLOT_DATA_SIZE
    };
    // ascii "RIFF", "WAVE", "fmt ", "data", indexed by status code
    localparam logic [31:0] TAG_WORD [5] = '{
        32'h0000_0000, 32'h5249_4646, 32'h5741_5645, 32'h666D_7420, 32'h6461_7461
    };
    localparam int TAG_POS [4] = '{0, 8, 12, 36};

    typedef struct {
        logic [31:0] riff_size, fmt_size;
        logic [15:0] fmt_tag, chans;
        logic [31:0] rate, brate;
        logic [15:0] align, bits;
        logic [31:0] dsize;
    } t_hdr_fields;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_wr_en;
    logic i_cfg_wr_data;

    wavhp_in_if  hdr_in ();
    wavhp_out_if hdr_out ();

    wav_header_parser uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_in         (hdr_in),
        .o_out        (hdr_out)
    );

    // decoder state mirrored in the testbench
    logic        pr_big_endian = 1'b0;
    int          pr_pos = 0;
    logic        pr_active = 1'b0;
    logic [31:0] pr_word = 32'd0;
    t_status     pr_err = ST_OK;
    logic [31:0] pr_store [9] = '{default: 32'd0};

    t_result     decoded_q [$];
    logic [7:0]  hbuf [HDR_BYTES];
    int          mismatches = 0;
    int          items_taken = 0;
    bit          no_idle = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("** wav_header_parser: FAILED **");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        if (mismatches < PRINT_LIMIT) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
        mismatches++;
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %h expected %h", name, got, want));
        end
    endtask

    function automatic void decode_header_byte(input logic [7:0] value, input logic first);
        int          f;
        int          k;
        logic [15:0] nchan;
        logic [15:0] bps;
        t_result     r;
        if (first) begin
            pr_pos = 0;
            pr_active = 1'b1;
            pr_word = 32'd0;
            pr_err = ST_OK;
        end
        if (!pr_active) begin
            return;
        end
        f = 0;
        for (int i = 0; i < 13; i++) begin
            if (pr_pos >= FIELD_AT[i]) begin
                f = i;
            end
        end
        k = pr_pos - FIELD_AT[f];
        if (k == 0) begin
            pr_word = 32'd0;
        end
        // tags are always msb first, numbers follow the byte order in force now
        if (FIELD_TAG[f] != ST_OK || pr_big_endian) begin
            pr_word = {pr_word[23:0], value};
        end else begin
            pr_word = pr_word | (32'(value) << (8 * k));
        end
        if (k + 1 == FIELD_LEN[f]) begin
            if (FIELD_TAG[f] != ST_OK) begin
                if (pr_word != TAG_WORD[FIELD_TAG[f]] && pr_err == ST_OK) begin
                    pr_err = FIELD_TAG[f];
                end
            end else begin
                pr_store[FIELD_SLOT[f]] = pr_word;
            end
        end
        pr_pos++;
        if (pr_pos < HDR_BYTES) begin
            return;
        end
        pr_active = 1'b0;
        pr_pos = 0;
        nchan = pr_store[SLOT_CHANNELS][15:0];
        bps = pr_store[SLOT_BITS][15:0] >> 3;
        r = '0;
        r.status = pr_err;
        if (pr_err == ST_OK && (nchan == 16'd0 || bps == 16'd0)) begin
            r.status = ST_ZERO_DIV;
        end
        if (r.status == ST_OK) begin
            r.fmt_chunk_size = pr_store[SLOT_FMT_SIZE];
            r.format_tag = pr_store[SLOT_FORMAT_TAG][15:0];
            r.channel_count = nchan;
            r.frame_rate = pr_store[SLOT_SAMPLE_RT];
            r.bytes_per_sec = pr_store[SLOT_BYTE_RT];
            r.block_align = pr_store[SLOT_BLK_ALIGN][15:0];
            r.bits_per_sample = pr_store[SLOT_BITS][15:0];
            r.data_bytes = pr_store[SLOT_DATA_SIZE];
            r.file_size = pr_store[SLOT_RIFF_SIZE] + 32'd8;
            r.sample_count = pr_store[SLOT_DATA_SIZE] / {16'd0, nchan} / {16'd0, bps};
        end
        decoded_q.push_back(r);
    endfunction

    // called at a rising edge; returns at the edge where the byte was taken
    task automatic push_header_byte(input logic [7:0] value, input logic first);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        repeat (gap) begin
            hdr_in.valid <= 1'b0;
            @(posedge i_clk);
        end
        hdr_in.valid       <= 1'b1;
        hdr_in.header_byte <= value;
        hdr_in.start_req   <= first;
        @(posedge i_clk);
        while (!hdr_in.ready) @(posedge i_clk);
        if (first || pr_active) begin
            items_taken++;
        end
        decode_header_byte(value, first);
    endtask

    // sender holds off until every pending result is in and the block is quiet
    task automatic settle_block();
        hdr_in.valid <= 1'b0;
        while (decoded_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_byte_order(input logic be);
        hdr_in.valid  <= 1'b0;
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= be;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        pr_big_endian = be;
    endtask

    function automatic void place_number(input int pos, input int len, input logic [31:0] value,
                                         input logic be);
        for (int i = 0; i < len; i++) begin
            hbuf[pos + i] = 8'(value >> (8 * (be ? len - 1 - i : i)));
        end
    endfunction

    function automatic void compose_header(input t_hdr_fields h, input logic be);
        for (int t = 0; t < 4; t++) begin
            place_number(TAG_POS[t], 4, TAG_WORD[t + 1], 1'b1);
        end
        place_number(4, 4, h.riff_size, be);
        place_number(16, 4, h.fmt_size, be);
        place_number(20, 2, 32'(h.fmt_tag), be);
        place_number(22, 2, 32'(h.chans), be);
        place_number(24, 4, h.rate, be);
        place_number(28, 4, h.brate, be);
        place_number(32, 2, 32'(h.align), be);
        place_number(34, 2, 32'(h.bits), be);
        place_number(40, 4, h.dsize, be);
    endfunction

    task automatic send_span(input int first_pos, input int last_pos);
        for (int i = first_pos; i <= last_pos; i++) begin
            push_header_byte(hbuf[i], i == 0);
        end
    endtask

    task automatic send_header(input t_hdr_fields h, input logic be);
        compose_header(h, be);
        send_span(0, HDR_BYTES - 1);
    endtask

    function automatic t_hdr_fields pcm_fields(input logic [15:0] chans, input logic [15:0] bits,
                                               input logic [31:0] dsize);
        t_hdr_fields h;
        h.riff_size = dsize + 32'd36;
        h.fmt_size = 32'd16;
        h.fmt_tag = 16'd1;
        h.chans = chans;
        h.rate = 32'd48000;
        h.align = 16'(chans * (bits >> 3));
        h.brate = 32'd48000 * 32'(h.align);
        h.bits = bits;
        h.dsize = dsize;
        return h;
    endfunction

    function automatic t_hdr_fields random_fields();
        t_hdr_fields h;
        h = pcm_fields(16'd1, 16'd16, $urandom());
        h.riff_size = $urandom();
        h.fmt_size = ($urandom_range(0, 1) == 0) ? 32'd16 : $urandom();
        h.fmt_tag = 16'($urandom());
        h.rate = $urandom();
        h.brate = $urandom();
        h.align = 16'($urandom());
        case ($urandom_range(0, 3))
            0, 1: h.chans = 16'($urandom_range(1, 8));
            2: h.chans = 16'($urandom());
            default: h.chans = 16'($urandom_range(0, 2));
        endcase
        case ($urandom_range(0, 3))
            0, 1: h.bits = 16'(8 * $urandom_range(1, 4));
            2: h.bits = 16'($urandom());
            default: h.bits = 16'($urandom_range(0, 15));
        endcase
        return h;
    endfunction

    function automatic logic pcm_big_or_little();
        return pr_big_endian;
    endfunction

    initial begin : result_checker
        int      stall;
        t_result want;
        hdr_out.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 4);
            repeat (stall) begin
                hdr_out.ready <= 1'b0;
                @(posedge i_clk);
            end
            hdr_out.ready <= 1'b1;
            @(posedge i_clk);
            while (!hdr_out.valid) @(posedge i_clk);
            if (decoded_q.size() == 0) begin
                report_mismatch("result with no header pending");
            end else begin
                want = decoded_q.pop_front();
                compare_field("status", 32'(hdr_out.status), 32'(want.status));
                compare_field("fmt_chunk_size", hdr_out.fmt_chunk_size, want.fmt_chunk_size);
                compare_field("format_tag", 32'(hdr_out.format_tag), 32'(want.format_tag));
                compare_field("channel_count", 32'(hdr_out.channel_count),
                              32'(want.channel_count));
                compare_field("frame_rate", hdr_out.frame_rate, want.frame_rate);
                compare_field("bytes_per_sec", hdr_out.bytes_per_sec, want.bytes_per_sec);
                compare_field("block_align", 32'(hdr_out.block_align), 32'(want.block_align));
                compare_field("bits_per_sample", 32'(hdr_out.bits_per_sample),
                              32'(want.bits_per_sample));
                compare_field("data_bytes", hdr_out.data_bytes, want.data_bytes);
                compare_field("file_size", hdr_out.file_size, want.file_size);
                compare_field("sample_count", hdr_out.sample_count, want.sample_count);
            end
        end
    end

    task automatic test_idle_bytes();
        push_header_byte(8'h00, 1'b0);
        push_header_byte(8'hFF, 1'b0);
        push_header_byte(8'h52, 1'b0);
    endtask

    task automatic test_good_headers();
        set_byte_order(1'b0);
        send_header(pcm_fields(16'd2, 16'd16, 32'd1_000_000), 1'b0);
        send_header(pcm_fields(16'd1, 16'd8, 32'd4095), 1'b0);
    endtask

    task automatic test_field_extremes();
        t_hdr_fields h;
        h = pcm_fields(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        h.riff_size = 32'hFFFF_FFFF;
        h.fmt_size = 32'hFFFF_FFFF;
        h.fmt_tag = 16'hFFFF;
        h.rate = 32'hFFFF_FFFF;
        h.brate = 32'hFFFF_FFFF;
        h.align = 16'hFFFF;
        send_header(h, pcm_big_or_little());
        h = pcm_fields(16'd1, 16'd8, 32'd0);
        h.riff_size = 32'd0;
        h.fmt_size = 32'd0;
        h.fmt_tag = 16'd0;
        h.rate = 32'd0;
        h.brate = 32'd0;
        send_header(h, pcm_big_or_little());
        // zero channels, then a sample width under one byte
        send_header(pcm_fields(16'd0, 16'd16, 32'd1000), pcm_big_or_little());
        send_header(pcm_fields(16'd2, 16'd7, 32'd1000), pcm_big_or_little());
    endtask

    task automatic test_tag_errors();
        for (int t = 0; t < 4; t++) begin
            compose_header(pcm_fields(16'd2, 16'd16, 32'd8000), pr_big_endian);
            hbuf[TAG_POS[t] + t] = hbuf[TAG_POS[t] + t] ^ 8'h20;
            send_span(0, HDR_BYTES - 1);
        end
        // several bad tags: the earliest one wins, and beats a zero divisor
        compose_header(pcm_fields(16'd0, 16'd0, 32'd8000), pr_big_endian);
        hbuf[TAG_POS[0]] = 8'h00;
        hbuf[TAG_POS[3] + 3] = 8'hFF;
        send_span(0, HDR_BYTES - 1);
        compose_header(pcm_fields(16'd2, 16'd16, 32'd8000), pr_big_endian);
        hbuf[TAG_POS[1] + 1] = 8'h80;
        hbuf[TAG_POS[2] + 2] = 8'h01;
        send_span(0, HDR_BYTES - 1);
    endtask

    task automatic test_restart();
        compose_header(pcm_fields(16'd2, 16'd24, 32'd60000), pr_big_endian);
        send_span(0, 20);
        send_span(0, HDR_BYTES - 1);
        send_span(0, HDR_BYTES - 2);
        send_span(0, HDR_BYTES - 1);
        // header done, so these are dropped
        push_header_byte(8'hA5, 1'b0);
        push_header_byte(8'h5A, 1'b0);
    endtask

    task automatic test_big_endian();
        settle_block();
        set_byte_order(1'b1);
        send_header(pcm_fields(16'd6, 16'd32, 32'h0123_4567), 1'b1);
        test_field_extremes();
        test_tag_errors();
    endtask

    task automatic test_order_switch_mid_field();
        settle_block();
        set_byte_order(1'b0);
        compose_header(pcm_fields(16'd2, 16'd16, 32'h00AB_CDEF), 1'b0);
        // stop inside the format chunk size and change byte order
        send_span(0, 17);
        settle_block();
        set_byte_order(1'b1);
        send_span(18, HDR_BYTES - 1);
        settle_block();
        set_byte_order(1'b0);
    endtask

    task automatic test_random_headers();
        int          sel;
        int          n;
        t_hdr_fields h;
        while (items_taken < ITEM_TARGET) begin
            sel = $urandom_range(0, 99);
            if (sel < 65) begin
                h = random_fields();
                compose_header(h, ($urandom_range(0, 9) == 0) ? !pr_big_endian : pr_big_endian);
                if ($urandom_range(0, 9) == 0) begin
                    n = $urandom_range(0, 3);
                    hbuf[TAG_POS[n] + $urandom_range(0, 3)] ^= 8'($urandom_range(1, 255));
                end
                send_span(0, HDR_BYTES - 1);
            end else if (sel < 75) begin
                compose_header(random_fields(), pr_big_endian);
                send_span(0, $urandom_range(0, HDR_BYTES - 2));
            end else if (sel < 83) begin
                n = $urandom_range(1, 6);
                repeat (n) begin
                    push_header_byte(8'($urandom()), $urandom_range(0, 7) == 0);
                end
            end else if (sel < 90) begin
                for (int i = 0; i < HDR_BYTES; i++) begin
                    hbuf[i] = 8'($urandom());
                end
                send_span(0, HDR_BYTES - 1);
            end else begin
                settle_block();
                if (!pr_active) begin
                    set_byte_order(1'($urandom_range(0, 1)));
                end
                no_idle = ($urandom_range(0, 3) == 0);
            end
        end
        no_idle = 1'b0;
    endtask

    initial begin
        i_rst_n            <= 1'b0;
        i_cfg_wr_en        <= 1'b0;
        i_cfg_wr_data      <= 1'b0;
        hdr_in.valid       <= 1'b0;
        hdr_in.header_byte <= 8'h00;
        hdr_in.start_req   <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_idle_bytes();
        test_good_headers();
        test_field_extremes();
        test_tag_errors();
        test_restart();
        test_big_endian();
        test_order_switch_mid_field();
        test_random_headers();

        settle_block();
        if (mismatches == 0) begin
            $display("** wav_header_parser: PASSED **");
        end else begin
            $display("** wav_header_parser: FAILED **");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/wavhp_pkg.sv
hdl/wavhp_ifs.sv
hdl/wavhp_assembler.sv
hdl/wavhp_divider.sv
hdl/wav_header_parser.sv
hdl/wavhp_checker.sv
tb/wav_header_parser_tb.sv
